[design/kmt_pkg.sv]
// Package for the killer move table: field widths, operation codes,
// row layout and the update record passed from the row logic to the top level.
// No dependencies.
`default_nettype none

package kmt_pkg;

  localparam int unsigned DefaultDepthRows = 256;
  localparam int unsigned DepthW           = 8;
  localparam int unsigned MoveW            = 16;
  localparam int unsigned SlotCount        = 3;
  localparam int unsigned RowW             = SlotCount * MoveW;
  localparam int unsigned OpW              = 2;
  localparam int unsigned OutDataW         = 8;
  localparam int unsigned InDataW          = 24;

  typedef enum logic [OpW-1:0] {
    OpInsert = 2'd0,
    OpQuery  = 2'd1,
    OpClear  = 2'd2,
    OpNone   = 2'd3
  } op_e;

  typedef logic [MoveW-1:0] move_t;

  typedef struct packed {
    move_t slot2;
    move_t slot1;
    move_t slot0;
  } row_t;

  typedef struct packed {
    logic hit;
    logic wr_en;
    logic clear;
    row_t wr_row;
  } upd_t;

endpackage

`default_nettype wire

[design/kmt_row_mem.sv]
// Row storage of the killer move table: one write port and one read port
// with a registered read. Depends on kmt_pkg.
`default_nettype none

module kmt_row_mem
  import kmt_pkg::*;
#(
  parameter int unsigned IdxW = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rd_en_i,
  input  wire logic [IdxW-1:0] rd_idx_i,
  output      row_t            rd_row_o,
  input  wire logic            wr_en_i,
  input  wire logic [IdxW-1:0] wr_idx_i,
  input  wire row_t            wr_row_i
);

  localparam int unsigned MemRows = 2 ** IdxW;

  row_t mem_q [MemRows];
  row_t rd_row_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_row_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_row_q <= mem_q[rd_idx_i];
    end
  end

  assign rd_row_o = rd_row_q;

endmodule

`default_nettype wire

[design/kmt_row_logic.sv]
// Compare and shift logic for one row: finds the move in the row and builds
// the row to write back. Depends on kmt_pkg.
`default_nettype none

module kmt_row_logic
  import kmt_pkg::*;
(
  input  wire op_e   op_i,
  input  wire logic  in_range_i,
  input  wire row_t  row_i,
  input  wire move_t move_i,
  output      upd_t  upd_o
);

  logic match0;
  logic match1;
  logic match2;

  assign match0 = (row_i.slot0 == move_i);
  assign match1 = (row_i.slot1 == move_i);
  assign match2 = (row_i.slot2 == move_i);

  always_comb begin
    upd_o              = '0;
    upd_o.wr_row.slot0 = move_i;
    upd_o.wr_row.slot1 = row_i.slot0;
    upd_o.wr_row.slot2 = row_i.slot1;
    unique case (op_i)
      OpInsert: begin
        upd_o.hit   = in_range_i && (match0 || match1 || match2);
        upd_o.wr_en = in_range_i && !match0 && !match1;
      end
      OpQuery: begin
        upd_o.hit = in_range_i && (match0 || match1 || match2);
      end
      OpClear: begin
        upd_o.clear = 1'b1;
      end
      default: begin
        upd_o.hit = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/killer_move_table_core.sv]
// Top level of the killer move table: input stage, row memory with write
// forwarding, row valid bits and the output register.
// Depends on kmt_pkg, kmt_row_mem and kmt_row_logic.
//
// Channel   Direction  Handshake              Payload
// s_axis    in         tvalid/tready          tuser = operation, tdata = depth, move_code
// m_axis    out        tvalid/tready          tdata = found
//
// One item per cycle is sustained unless the output stalls; results pass the update
// stage, then the output register. The row is read at acceptance, modified and written
// back when the item leaves; the most recent write is forwarded to a read of the same row.
// Reset clears all row valid bits, so every row reads as zeros; no clearing pass.
// A stalled output holds one result while one more item waits in the update stage.
`default_nettype none

module killer_move_table_core
  import kmt_pkg::*;
#(
  parameter int unsigned DEPTH_ROWS = DefaultDepthRows
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output      logic                s_axis_tready_o,
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,   // [7:0] depth, [23:8] move_code
  input  wire logic [OpW-1:0]      s_axis_tuser_i,   // [1:0] operation
  output      logic                m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output      logic [OutDataW-1:0] m_axis_tdata_o    // [0] found, [7:1] zero
);

  localparam int unsigned NumRows = (DEPTH_ROWS < 256) ? DEPTH_ROWS : 256;
  localparam int unsigned IdxW    = $clog2(NumRows);
  localparam int unsigned MemRows = 2 ** IdxW;

  logic [DepthW-1:0] in_depth;
  move_t             in_move;
  logic              in_fire;
  logic [IdxW-1:0]   in_idx;

  logic              s1_valid_q, s1_valid_d;
  op_e               s1_op_q;
  logic [IdxW-1:0]   s1_idx_q;
  logic              s1_in_range_q;
  move_t             s1_move_q;
  logic              s1_fire;

  logic              fwd_valid_q;
  logic [IdxW-1:0]   fwd_idx_q;
  row_t              fwd_row_q;

  logic [MemRows-1:0] row_valid_q, row_valid_d;

  logic              out_valid_q, out_valid_d;
  logic              out_found_q;

  row_t              mem_row;
  row_t              cur_row;
  upd_t              upd;
  logic              wr_en;

  assign in_depth = s_axis_tdata_i[DepthW-1:0];
  assign in_move  = s_axis_tdata_i[DepthW+MoveW-1:DepthW];
  assign in_idx   = in_depth[IdxW-1:0];

  assign s1_fire         = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_fire;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  kmt_row_mem #(
    .IdxW(IdxW)
  ) u_row_mem (
    .clk_i   (clk_i),
    .rd_en_i (in_fire),
    .rd_idx_i(in_idx),
    .rd_row_o(mem_row),
    .wr_en_i (wr_en),
    .wr_idx_i(s1_idx_q),
    .wr_row_i(upd.wr_row)
  );

  always_comb begin
    cur_row = '0;
    if (row_valid_q[s1_idx_q]) begin
      cur_row = (fwd_valid_q && (fwd_idx_q == s1_idx_q)) ? fwd_row_q : mem_row;
    end
  end

  kmt_row_logic u_row_logic (
    .op_i      (s1_op_q),
    .in_range_i(s1_in_range_q),
    .row_i     (cur_row),
    .move_i    (s1_move_q),
    .upd_o     (upd)
  );

  assign wr_en = s1_fire && upd.wr_en;

  always_comb begin
    row_valid_d = row_valid_q;
    if (s1_fire && upd.clear) begin
      row_valid_d = '0;
    end else if (wr_en) begin
      row_valid_d[s1_idx_q] = 1'b1;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_valid_q <= 1'b0;
      row_valid_q <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      row_valid_q <= row_valid_d;
      if (wr_en) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q       <= op_e'(s_axis_tuser_i);
      s1_idx_q      <= in_idx;
      s1_in_range_q <= (32'(in_depth) < DEPTH_ROWS);
      s1_move_q     <= in_move;
    end
    if (wr_en) begin
      fwd_idx_q <= s1_idx_q;
      fwd_row_q <= upd.wr_row;
    end
    if (s1_fire) begin
      out_found_q <= upd.hit;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW-1){1'b0}}, out_found_q};

endmodule

`default_nettype wire

[design/kmt_checker.sv]
// Port-level checks for the killer move table, bound to its top level.
// Depends on kmt_pkg and killer_move_table_core.
`default_nettype none

module kmt_checker
  import kmt_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tready_o,
  input wire logic                m_axis_tvalid_o,
  input wire logic                m_axis_tready_i,
  input wire logic [OutDataW-1:0] m_axis_tdata_o
);

  // A result that is not taken stays offered unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("Stalled output transaction changed.");

  // The input side is only held off when a result is waiting downstream.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("Input stalled without a stalled output.");

  // Only the found bit may be set in the output data.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[OutDataW-1:1] == '0))
    else $error("Output padding bits are not zero.");

  // No result is offered while in reset or in the cycle after it.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("Output valid right after reset.");

endmodule

bind killer_move_table_core kmt_checker u_kmt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);

`default_nettype wire
